>>> sv/kbd_pkg.sv
// Shared constants, types and helpers of the key binding dispatcher.
package kbd_pkg;

    localparam int KEYS         = 512;
    localparam int CLASSES      = 8;
    localparam int GAME_ACTIONS = 128;
    localparam int ACTION_IDS   = 1024;

    localparam int FUNC_W  = 3;
    localparam int KCODE_W = 10;
    localparam int CLS_W   = 3;
    localparam int ACT_W   = 10;
    localparam int CNT_W   = 10;

    localparam int KEY_W       = $clog2(KEYS);
    localparam int SLOT_DEPTH  = KEYS * CLASSES;
    localparam int SLOT_AW     = $clog2(SLOT_DEPTH);
    localparam int CNT_DEPTH   = CLASSES * GAME_ACTIONS;
    localparam int CNT_AW      = $clog2(CNT_DEPTH);
    localparam int SWEEP_LEN   = (SLOT_DEPTH > CNT_DEPTH) ? SLOT_DEPTH : CNT_DEPTH;
    localparam int SW_W        = $clog2(SWEEP_LEN + 1);

    localparam logic [CNT_W-1:0]   COUNT_MAX    = 10'd1023;
    localparam logic [KCODE_W-1:0] CHAR_UPPER_A = 10'd65;
    localparam logic [KCODE_W-1:0] CHAR_UPPER_Z = 10'd90;
    localparam logic [KCODE_W-1:0] CASE_OFFSET  = 10'd32;

    typedef enum logic [FUNC_W-1:0] {
        FN_DOWN   = 3'd0,
        FN_UP     = 3'd1,
        FN_BIND   = 3'd2,
        FN_MENU   = 3'd3,
        FN_UNBIND = 3'd4,
        FN_CLEAR  = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_READ,
        S_CNT
    } t_state;

    typedef enum logic [1:0] {
        CNT_NONE,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    // one entry of the key/class store
    typedef struct packed {
        logic             held;
        logic             valid;
        logic [ACT_W-1:0] act;
    } t_slot;

    // decoded request from the input side
    typedef struct packed {
        t_func                func;
        logic [SLOT_AW-1:0]   slot_idx;
        logic [CLS_W-1:0]     cls;
        logic [ACT_W-1:0]     act;
        logic                 act_ok;
        logic                 cancel;
        logic                 console;
        logic                 en;
    } t_req;

    typedef struct packed {
        logic             action_valid;
        logic [ACT_W-1:0] bound_action;
        logic             all_released;
        logic             run_command;
    } t_res;

    function automatic logic [KCODE_W-1:0] f_fold_lower(input logic [KCODE_W-1:0] k);
        if (k >= CHAR_UPPER_A && k <= CHAR_UPPER_Z) begin
            return k + CASE_OFFSET;
        end
        return k;
    endfunction

endpackage

>>> sv/kbd_if.sv
// Valid/ready channel interfaces for key events and dispatch results.
interface kbd_evt_if;
    logic                        valid;
    logic                        ready;
    logic [kbd_pkg::FUNC_W-1:0]  func;
    logic [kbd_pkg::KCODE_W-1:0] key_code;
    logic [kbd_pkg::CLS_W-1:0]   binding_class;
    logic [kbd_pkg::ACT_W-1:0]   action_id;
    logic                        cancel;
    logic                        console_open;

    modport source (output valid, func, key_code, binding_class, action_id, cancel,
                    console_open, input ready);
    modport sink   (input valid, func, key_code, binding_class, action_id, cancel,
                    console_open, output ready);
endinterface

interface kbd_res_if;
    logic                      valid;
    logic                      ready;
    logic                      action_valid;
    logic [kbd_pkg::ACT_W-1:0] bound_action;
    logic                      all_released;
    logic                      run_command;

    modport source (output valid, action_valid, bound_action, all_released, run_command,
                    input ready);
    modport sink   (input valid, action_valid, bound_action, all_released, run_command,
                    output ready);
endinterface

>>> sv/kbd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module kbd_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

>>> sv/kbd_seq.sv
// Sequencer: clearing sweep and read-modify-write of the slot and count memories.
module kbd_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  kbd_pkg::t_req i_req,
    input  logic          i_out_free,
    output logic          o_res_load,
    output kbd_pkg::t_res o_res
);
    import kbd_pkg::*;

    t_state  r_state, n_state;
    logic [SW_W-1:0] r_sw, n_sw;
    logic    r_full, n_full;
    logic    accept;

    t_req    r_req;
    t_cnt_op r_op;
    logic    r_chk;
    logic [CNT_AW-1:0] r_cidx;
    t_res    r_res_part;

    // slot memory
    logic s_we, s_re;
    logic [SLOT_AW-1:0] s_waddr, s_raddr;
    t_slot s_wdata, s_rdata;
    // count memory
    logic c_we, c_re;
    logic [CNT_AW-1:0] c_waddr, c_raddr;
    logic [CNT_W-1:0]  c_wdata, c_rdata;

    // slot update stage results
    t_slot   b_slot;
    logic    b_we;
    t_cnt_op b_op;
    logic    b_chk;
    logic [CNT_AW-1:0] b_cidx;
    t_res    b_res;
    logic [CNT_W-1:0]  cnt_new;
    logic [SW_W-1:0]   sw_m1;

    kbd_ram #(.DEPTH(SLOT_DEPTH), .WIDTH($bits(t_slot))) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(s_wdata),
        .i_re   (s_re),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    kbd_ram #(.DEPTH(CNT_DEPTH), .WIDTH(CNT_W)) u_cnt_ram (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_waddr(c_waddr),
        .i_wdata(c_wdata),
        .i_re   (c_re),
        .i_raddr(c_raddr),
        .o_rdata(c_rdata)
    );

    // slot read-modify-write decision
    always_comb begin
        logic             wasdown;
        logic             bv;
        logic [ACT_W-1:0] ba;
        logic             ba_game;
        logic             act_game;
        logic [ACT_W-1:0] cact;
        wasdown  = s_rdata.held;
        bv       = s_rdata.valid;
        ba       = bv ? s_rdata.act : '0;
        ba_game  = {1'b0, ba} < (ACT_W+1)'(GAME_ACTIONS);
        act_game = {1'b0, r_req.act} < (ACT_W+1)'(GAME_ACTIONS);
        b_slot   = s_rdata;
        b_we     = 1'b0;
        b_op     = CNT_NONE;
        b_chk    = 1'b0;
        b_res    = '0;
        cact     = (r_req.func == FN_MENU) ? r_req.act : ba;
        b_cidx   = CNT_AW'(int'(r_req.cls) * GAME_ACTIONS + int'(cact));
        if (r_req.en) begin
            unique case (r_req.func)
                FN_DOWN: begin
                    b_slot.held = 1'b1;
                    b_we        = 1'b1;
                    if (bv) begin
                        b_res.action_valid = 1'b1;
                        b_res.bound_action = ba;
                        if (!ba_game) begin
                            b_res.run_command = !r_req.console;
                        end else if (!wasdown) begin
                            b_op = CNT_INC;
                        end
                    end
                end
                FN_UP: begin
                    b_slot.held = 1'b0;
                    b_we        = 1'b1;
                    if (bv) begin
                        b_res.action_valid = 1'b1;
                        b_res.bound_action = ba;
                        if (ba_game) begin
                            b_chk = 1'b1;
                            if (wasdown) begin
                                b_op = CNT_DEC;
                            end
                        end
                    end
                end
                FN_BIND: begin
                    if (r_req.act_ok) begin
                        b_slot.valid = 1'b1;
                        b_slot.act   = r_req.act;
                        b_we         = 1'b1;
                    end
                end
                FN_MENU: begin
                    if (!r_req.cancel && r_req.act_ok) begin
                        if (bv && ba == r_req.act) begin
                            b_slot.valid = 1'b0;
                            b_slot.act   = '0;
                        end else begin
                            b_slot.valid = 1'b1;
                            b_slot.act   = r_req.act;
                        end
                        b_slot.held = 1'b0;
                        b_we        = 1'b1;
                        if (wasdown && act_game) begin
                            b_op = CNT_DEC;
                        end
                    end
                end
                FN_UNBIND: begin
                    b_slot.valid = 1'b0;
                    b_slot.act   = '0;
                    b_we         = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // saturating count update
    always_comb begin
        unique case (r_op)
            CNT_INC: cnt_new = (c_rdata == COUNT_MAX) ? c_rdata : c_rdata + 1'b1;
            CNT_DEC: cnt_new = (c_rdata == '0) ? c_rdata : c_rdata - 1'b1;
            default: cnt_new = c_rdata;
        endcase
    end

    always_comb begin
        o_res = r_res_part;
        o_res.all_released = r_chk && (cnt_new == '0);
    end

    assign sw_m1 = r_sw - 1'b1;

    // next state and memory port control
    always_comb begin
        n_state     = r_state;
        n_sw        = r_sw;
        n_full      = r_full;
        o_req_ready = 1'b0;
        o_res_load  = 1'b0;
        accept      = 1'b0;
        s_we        = 1'b0;
        s_waddr     = r_req.slot_idx;
        s_wdata     = b_slot;
        s_re        = 1'b0;
        s_raddr     = i_req.slot_idx;
        c_we        = 1'b0;
        c_waddr     = r_cidx;
        c_wdata     = cnt_new;
        c_re        = 1'b0;
        c_raddr     = b_cidx;
        unique case (r_state)
            S_SWEEP: begin
                // read entry n, write back n-1: held bit cleared, all after reset
                s_raddr = r_sw[SLOT_AW-1:0];
                s_re    = r_sw < SW_W'(SLOT_DEPTH);
                s_waddr = sw_m1[SLOT_AW-1:0];
                s_we    = (r_sw != '0) && (r_sw <= SW_W'(SLOT_DEPTH));
                s_wdata = r_full ? '0 : t_slot'{held: 1'b0, valid: s_rdata.valid,
                                                act: s_rdata.act};
                c_waddr = r_sw[CNT_AW-1:0];
                c_wdata = '0;
                c_we    = r_sw < SW_W'(CNT_DEPTH);
                if (r_sw == SW_W'(SWEEP_LEN)) begin
                    n_state = r_full ? S_IDLE : S_CNT;
                end else begin
                    n_sw = r_sw + 1'b1;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                accept      = i_req_valid;
            end
            S_READ: begin
                s_we    = b_we;
                c_re    = 1'b1;
                n_state = S_CNT;
            end
            S_CNT: begin
                o_res_load = i_out_free;
                c_we       = i_out_free && (r_op != CNT_NONE);
                if (i_out_free) begin
                    o_req_ready = 1'b1;
                    accept      = i_req_valid;
                    n_state     = S_IDLE;
                end
            end
        endcase
        if (accept) begin
            s_re    = 1'b1;
            s_raddr = i_req.slot_idx;
            if (i_req.func == FN_CLEAR) begin
                n_state = S_SWEEP;
                n_sw    = '0;
                n_full  = 1'b0;
            end else begin
                n_state = S_READ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_sw    <= '0;
            r_full  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_sw    <= n_sw;
            r_full  <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req      <= i_req;
            r_op       <= CNT_NONE;
            r_chk      <= 1'b0;
            r_res_part <= '0;
        end else if (r_state == S_READ) begin
            r_op       <= b_op;
            r_chk      <= b_chk;
            r_cidx     <= b_cidx;
            r_res_part <= b_res;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |-> i_out_free)
        else $error("result loaded while output register busy");

    a_sweep_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !o_req_ready)
        else $error("transaction accepted during clearing sweep");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> (r_state == S_READ || r_state == S_SWEEP))
        else $error("accepted transaction not started");

    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CNT && !i_out_free) |=> (r_state == S_CNT && $stable(r_op)))
        else $error("count update lost while output stalled");

    a_res_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |-> !(o_res.all_released && o_res.run_command))
        else $error("release and command flagged together");
endmodule

>>> sv/key_binding_dispatcher_core.sv
// Key binding dispatcher top level: request decode, sequencer and output register.
//
// Each key event transaction returns exactly one result transaction. Key
// down/up, bind, menu toggle bind and unbind go through a read-modify-write of
// a slot memory (held bit plus binding per key and class), then of a
// pressed-count memory (per class and game action): the slot is read as the
// transaction is accepted, the next cycle writes it back and reads the count,
// and then, once the output register is free, the count is updated and the
// result loaded. The next transaction is taken as that load happens, so a
// new event is accepted while the previous one finishes its count update.
// Clear key states walks both memories, one entry per cycle, before its
// all-zero result appears. After reset the same walk clears all stores,
// including bindings: no event is taken until the walk is done. Codes A-Z
// are folded to lower case except for menu toggle bind; keys or classes out
// of range, and unused function codes, change nothing and return an all-zero
// result. A one-entry output register lets a new event be taken while the
// previous result waits on the sink.
module key_binding_dispatcher_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kbd_evt_if.sink    i_evt,
    kbd_res_if.source  o_res
);
    import kbd_pkg::*;

    t_req req;
    logic req_ready;
    logic out_free;
    logic res_load;
    t_res res;

    logic r_out_valid;
    t_res r_out;

    // request decode: range checks, case folding, slot address
    always_comb begin
        logic [KCODE_W-1:0] k;
        logic [KEY_W-1:0]   k_idx;
        logic               key_ok;
        logic               cls_ok;
        key_ok = {1'b0, i_evt.key_code} < (KCODE_W+1)'(KEYS);
        cls_ok = {1'b0, i_evt.binding_class} < (CLS_W+1)'(CLASSES);
        k = (t_func'(i_evt.func) == FN_MENU) ? i_evt.key_code
                                             : f_fold_lower(i_evt.key_code);
        if (!({1'b0, k} < (KCODE_W+1)'(KEYS))) begin
            k = i_evt.key_code;
        end
        k_idx = k[KEY_W-1:0];

        req.func     = t_func'(i_evt.func);
        req.slot_idx = SLOT_AW'(int'(k_idx) * CLASSES + int'(i_evt.binding_class));
        req.cls      = i_evt.binding_class;
        req.act      = i_evt.action_id;
        req.act_ok   = {1'b0, i_evt.action_id} < (ACT_W+1)'(ACTION_IDS);
        req.cancel   = i_evt.cancel;
        req.console  = i_evt.console_open;
        req.en       = (i_evt.func <= FN_UNBIND) && key_ok && cls_ok;
    end

    assign i_evt.ready = req_ready;

    kbd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_evt.valid),
        .o_req_ready(req_ready),
        .i_req      (req),
        .i_out_free (out_free),
        .o_res_load (res_load),
        .o_res      (res)
    );

    // output register
    assign out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.action_valid = r_out.action_valid;
    assign o_res.bound_action = r_out.bound_action;
    assign o_res.all_released = r_out.all_released;
    assign o_res.run_command  = r_out.run_command;
endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the key binding dispatcher: directed table, then random traffic.
module testbench;
    import kbd_pkg::*;

    localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

    localparam int RANDOM_ITEMS    = 1375;
    localparam int PHASES          = 5;
    localparam int IDLE_PCT [PHASES]  = '{0, 86, 0, 27, 0};
    localparam int STALL_PCT [PHASES] = '{0, 0, 86, 27, 0};
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 16;
    // outlasts the reset walk, a clear walk and sink stalls, which pass no handshake
    localparam int WATCHDOG_LIMIT  = 20000;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [KCODE_W-1:0] key;
        logic [CLS_W-1:0]   cls;
        logic [ACT_W-1:0]   act;
        logic               cancel;
        logic               console;
        bit                 fixed;      // result typed in below, not predicted
        logic               w_valid;
        logic [ACT_W-1:0]   w_act;
        logic               w_released;
        logic               w_run;
    } t_key_event;

    // func, key, class, action, cancel, console | fixed, valid, action, released, run
    t_key_event directed_rows [25] = '{
        '{FN_DOWN,    97,   0,    0, 0, 0,  1, 0, 0, 0, 0},  // unbound key after reset
        '{FN_BIND,    65,   0,    5, 0, 0,  1, 0, 0, 0, 0},  // 'A' binds as 'a'
        '{FN_DOWN,    97,   0,    0, 0, 0,  1, 1, 5, 0, 0},
        '{FN_DOWN,    65,   0,    0, 0, 0,  0, 0, 0, 0, 0},
        '{FN_UP,      97,   0,    0, 0, 0,  0, 0, 0, 0, 0},
        '{FN_UP,      65,   0,    0, 0, 0,  0, 0, 0, 0, 0},  // count already zero
        '{FN_BIND,    1023, 7,  127, 0, 0,  1, 0, 0, 0, 0},  // key out of range
        '{FN_DOWN,    1023, 7,    0, 0, 0,  1, 0, 0, 0, 0},
        '{FN_BIND,    511,  7, 1023, 0, 0,  1, 0, 0, 0, 0},  // console command
        '{FN_DOWN,    511,  7,    0, 0, 0,  0, 0, 0, 0, 0},
        '{FN_DOWN,    511,  7,    0, 0, 1,  0, 0, 0, 0, 0},  // console open
        '{FN_MENU,    90,   3,  127, 0, 0,  1, 0, 0, 0, 0},  // 'Z' kept as is
        '{FN_DOWN,    90,   3,    0, 0, 0,  0, 0, 0, 0, 0},
        '{FN_MENU,    90,   3,  127, 1, 0,  1, 0, 0, 0, 0},  // cancelled
        '{FN_MENU,    90,   3,  127, 0, 0,  1, 0, 0, 0, 0},  // toggles off, drops held
        '{FN_UP,      90,   3,    0, 0, 0,  0, 0, 0, 0, 0},
        '{FN_DOWN,    122,  3,    0, 0, 0,  0, 0, 0, 0, 0},
        '{FN_SPARE_A, 97,   0, 1023, 1, 1,  1, 0, 0, 0, 0},
        '{FN_SPARE_B, 1023, 7, 1023, 1, 1,  1, 0, 0, 0, 0},
        '{FN_BIND,    0,    0,    0, 0, 0,  1, 0, 0, 0, 0},
        '{FN_DOWN,    0,    0,    0, 0, 0,  0, 0, 0, 0, 0},
        '{FN_UNBIND,  65,   0,    0, 0, 0,  1, 0, 0, 0, 0},
        '{FN_DOWN,    97,   0,    0, 0, 0,  0, 0, 0, 0, 0},
        '{FN_CLEAR,   0,    0,    0, 0, 0,  1, 0, 0, 0, 0},
        '{FN_UP,      0,    0,    0, 0, 0,  0, 0, 0, 0, 0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    kbd_evt_if evt_bus ();
    kbd_res_if res_bus ();

    key_binding_dispatcher_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_bus),
        .o_res   (res_bus)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the key stores
    bit              held_map   [SLOT_DEPTH];
    bit              bound_ok   [SLOT_DEPTH];
    bit [ACT_W-1:0]  bound_act  [SLOT_DEPTH];
    bit [CNT_W-1:0]  press_tally[CNT_DEPTH];

    t_res expected_results [$];
    int   error_count     = 0;
    int   sender_idle_pct = 0;
    int   sink_stall_pct  = 0;
    bit   hold_req        = 1'b0;
    int   hold_left       = 0;
    int   quiet_cycles    = 0;

    function automatic t_res dispatch_event(input t_key_event ev);
        t_res             r;
        logic [KCODE_W-1:0] k;
        int unsigned      slot;
        int unsigned      ci;
        bit               was_held;
        r = '0;
        if (ev.func == FN_CLEAR) begin
            foreach (held_map[i]) held_map[i] = 1'b0;
            foreach (press_tally[i]) press_tally[i] = '0;
        end else if (ev.func <= FN_UNBIND && ev.key < KEYS && ev.cls < CLASSES) begin
            k = ev.key;
            // menu toggle bind keeps the raw code
            if (ev.func != FN_MENU && k >= CHAR_UPPER_A && k <= CHAR_UPPER_Z) begin
                k = k + CASE_OFFSET;
            end
            slot     = k * CLASSES + ev.cls;
            was_held = held_map[slot];
            case (ev.func)
                FN_DOWN: begin
                    held_map[slot] = 1'b1;
                    if (bound_ok[slot]) begin
                        r.action_valid = 1'b1;
                        r.bound_action = bound_act[slot];
                        ci = ev.cls * GAME_ACTIONS + bound_act[slot];
                        if (bound_act[slot] >= GAME_ACTIONS) begin
                            r.run_command = !ev.console;
                        end else if (!was_held && press_tally[ci] < COUNT_MAX) begin
                            press_tally[ci]++;
                        end
                    end
                end
                FN_UP: begin
                    held_map[slot] = 1'b0;
                    if (bound_ok[slot]) begin
                        r.action_valid = 1'b1;
                        r.bound_action = bound_act[slot];
                        if (bound_act[slot] < GAME_ACTIONS) begin
                            ci = ev.cls * GAME_ACTIONS + bound_act[slot];
                            if (was_held && press_tally[ci] != 0) press_tally[ci]--;
                            r.all_released = (press_tally[ci] == 0);
                        end
                    end
                end
                FN_BIND: begin
                    if (ev.act < ACTION_IDS) begin
                        bound_ok[slot]  = 1'b1;
                        bound_act[slot] = ev.act;
                    end
                end
                FN_MENU: begin
                    if (!ev.cancel && ev.act < ACTION_IDS) begin
                        if (bound_ok[slot] && bound_act[slot] == ev.act) begin
                            bound_ok[slot]  = 1'b0;
                            bound_act[slot] = '0;
                        end else begin
                            bound_ok[slot]  = 1'b1;
                            bound_act[slot] = ev.act;
                        end
                        held_map[slot] = 1'b0;
                        ci = ev.cls * GAME_ACTIONS + ev.act;
                        if (was_held && ev.act < GAME_ACTIONS && press_tally[ci] != 0) begin
                            press_tally[ci]--;
                        end
                    end
                end
                FN_UNBIND: begin
                    bound_ok[slot]  = 1'b0;
                    bound_act[slot] = '0;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // small key and action pools so binds, presses and releases meet often
    function automatic t_key_event random_event();
        t_key_event ev;
        int         r;
        ev = '{default: '0};
        r = $urandom_range(99);
        if (r < 34)      ev.func = FN_DOWN;
        else if (r < 68) ev.func = FN_UP;
        else if (r < 80) ev.func = FN_BIND;
        else if (r < 89) ev.func = FN_MENU;
        else if (r < 95) ev.func = FN_UNBIND;
        else if (r < 98) ev.func = $urandom_range(1) ? FN_SPARE_A : FN_SPARE_B;
        else             ev.func = FN_CLEAR;
        r = $urandom_range(99);
        if (r < 40)      ev.key = KCODE_W'(($urandom_range(1) ? 97 : 65) + $urandom_range(7));
        else if (r < 70) ev.key = KCODE_W'($urandom_range(15));
        else if (r < 85) ev.key = KCODE_W'(496 + $urandom_range(15));
        else if (r < 93) ev.key = KCODE_W'($urandom_range(KEYS - 1));
        else             ev.key = KCODE_W'($urandom_range(1023, KEYS));
        ev.cls = CLS_W'(($urandom_range(99) < 60) ? $urandom_range(1)
                                                  : $urandom_range(CLASSES - 1));
        r = $urandom_range(99);
        if (r < 50)      ev.act = ACT_W'($urandom_range(7));
        else if (r < 65) ev.act = ACT_W'($urandom_range(GAME_ACTIONS - 1, GAME_ACTIONS - 8));
        else if (r < 80) ev.act = ACT_W'($urandom_range(GAME_ACTIONS + 7, GAME_ACTIONS));
        else if (r < 90) ev.act = ACT_W'($urandom_range(1023));
        else             ev.act = ACT_W'($urandom_range(1023, 1016));
        ev.cancel  = ($urandom_range(99) < 25);
        ev.console = ($urandom_range(99) < 30);
        return ev;
    endfunction

    // drive one transaction from the falling edge, record its result on acceptance
    task automatic send_event(input t_key_event ev);
        t_res want;
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            evt_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        evt_bus.valid         = 1'b1;
        evt_bus.func          = ev.func;
        evt_bus.key_code      = ev.key;
        evt_bus.binding_class = ev.cls;
        evt_bus.action_id     = ev.act;
        evt_bus.cancel        = ev.cancel;
        evt_bus.console_open  = ev.console;
        do @(posedge i_clk); while (!evt_bus.ready);
        want = dispatch_event(ev);
        if (ev.fixed) want = {ev.w_valid, ev.w_act, ev.w_released, ev.w_run};
        expected_results.push_back(want);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            res_bus.ready = 1'b0;
            hold_left--;
        end else begin
            res_bus.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result transaction, action %0d", $time,
                         res_bus.bound_action);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("action_valid", want.action_valid, res_bus.action_valid);
                check_field("bound_action", want.bound_action, res_bus.bound_action);
                check_field("all_released", want.all_released, res_bus.all_released);
                check_field("run_command", want.run_command, res_bus.run_command);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((evt_bus.valid && evt_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        i_rst_n               = 1'b0;
        evt_bus.valid         = 1'b0;
        evt_bus.func          = FN_DOWN;
        evt_bus.key_code      = '0;
        evt_bus.binding_class = '0;
        evt_bus.action_id     = '0;
        evt_bus.cancel        = 1'b0;
        evt_bus.console_open  = 1'b0;
        res_bus.ready         = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) send_event(directed_rows[i]);

        for (int p = 0; p < PHASES; p++) begin
            sender_idle_pct = IDLE_PCT[p];
            sink_stall_pct  = STALL_PCT[p];
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                // long sink hold-off while the sender keeps pushing
                if (p == 0 && n == 100) hold_req = 1'b1;
                // sender goes quiet until everything has drained
                if (p == 1 && n == 150) begin
                    @(negedge i_clk);
                    evt_bus.valid = 1'b0;
                    while (expected_results.size() != 0) @(posedge i_clk);
                end
                send_event(random_event());
            end
        end

        @(negedge i_clk);
        evt_bus.valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
sv/kbd_pkg.sv
sv/kbd_if.sv
sv/kbd_ram.sv
sv/kbd_seq.sv
sv/key_binding_dispatcher_core.sv
tb/sv/testbench.sv
